// ----- rtl/core/tlcc_pkg.sv -----
// shared types and constants of the line crossing counter
package tlcc_pkg;

   localparam int TABLE_DEPTH_DEF = 32;
   localparam int MAX_RESULTS     = 32;
   localparam logic [15:0] AGE_DEF = 16'd50;

   localparam logic [1:0] MODE_REPORT = 2'd0;
   localparam logic [1:0] MODE_FRAME  = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;

   typedef struct packed {
      logic [15:0]        id;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic               seen;
   } entry_type;

endpackage

// ----- rtl/core/tlcc_ifs.sv -----
// handshake channels for request and response words
interface tlcc_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic [15:0]        target_id;
   logic [15:0]        track_age;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   modport source (output valid, mode, target_id, track_age, pos_x, pos_y, input ready);
   modport sink   (input valid, mode, target_id, track_age, pos_x, pos_y, output ready);
endinterface

interface tlcc_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        entry_id;
   logic               seen_now;
   logic signed [15:0] entry_x;
   logic signed [15:0] entry_y;
   logic [15:0]        right_total;
   logic [15:0]        left_total;
   logic               table_overflow;
   logic               last_in_frame;
   modport source (output valid, entry_id, seen_now, entry_x, entry_y, right_total,
                   left_total, table_overflow, last_in_frame, input ready);
   modport sink   (input valid, entry_id, seen_now, entry_x, entry_y, right_total,
                   left_total, table_overflow, last_in_frame, output ready);
endinterface

// ----- rtl/core/tracked_id_line_crossing_counter_unit.sv -----
// top level of the tracked id line crossing counter
// the table of tracked ids sits in a rotating register line of TABLE_DEPTH slots; one id
// compare and one position update act on the head slot, and a small sequencer turns the
// line once per counted report or end of frame. a counted report turns it over the entries
// held and then inserts the id if it was new; an end of frame turns it over them and waits
// while the response side stalls; a counter reset or an ignored report needs no turn. no
// new request word is taken while a turn is under way.
// end of frame sends one word per entry in table order, at most MAX_RESULTS of them,
// and drops unmarked entries on the same turn. counters saturate at all ones.
module tracked_id_line_crossing_counter_unit
   import tlcc_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   tlcc_req_if.sink    req_chan,
   tlcc_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int EW = $clog2(MAX_RESULTS + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_FRAME = 2'd2;

   // table line, no reset on payload
   entry_type tab_ff [TABLE_DEPTH];
   entry_type tab_in [TABLE_DEPTH];
   entry_type rot_src [TABLE_DEPTH];
   entry_type ins_src [TABLE_DEPTH];

   logic [1:0]         state_ff, state_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [CW-1:0]      rem_ff, rem_in;
   logic [CW-1:0]      kept_ff, kept_in;
   logic [EW-1:0]      emit_ff, emit_in;
   logic               found_ff, found_in;
   logic [15:0]        id_ff, id_in;
   logic signed [15:0] x_ff, x_in;
   logic signed [15:0] y_ff, y_in;
   logic [15:0]        right_ff, right_in;
   logic [15:0]        left_ff, left_in;
   logic               ovf_ff, ovf_in;
   logic [15:0]        age_ff, age_in;

   // output register
   logic               ovalid_ff, ovalid_in;
   entry_type          oent_ff, oent_in;
   logic [15:0]        oright_ff, oright_in;
   logic [15:0]        oleft_ff, oleft_in;
   logic               oovf_ff, oovf_in;
   logic               olast_ff, olast_in;

   entry_type          head;
   entry_type          wrap_data;
   logic [CW-1:0]      total;
   logic [IW-1:0]      wrap;
   logic               keep;
   logic               step;
   logic               match;
   logic               out_free;

   // neighbour taps of each slot, for turning and for front insert
   genvar g;
   generate
      for (g = 0; g < TABLE_DEPTH; g++) begin : g_taps
         if (g < TABLE_DEPTH - 1) begin : g_r
            assign rot_src[g] = tab_ff[g + 1];
         end else begin : g_rl
            assign rot_src[g] = tab_ff[0];
         end
         if (g > 0) begin : g_i
            assign ins_src[g] = tab_ff[g - 1];
         end else begin : g_i0
            assign ins_src[g] = tab_ff[0];
         end
      end
   endgenerate

   assign head     = tab_ff[0];
   assign total    = rem_ff + kept_ff;
   assign wrap     = IW'(total - CW'(1));
   assign out_free = !ovalid_ff || rsp_chan.ready;
   assign match    = !found_ff && (head.id == id_ff);

   assign req_chan.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      kept_in   = kept_ff;
      emit_in   = emit_ff;
      found_in  = found_ff;
      id_in     = id_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      right_in  = right_ff;
      left_in   = left_ff;
      ovf_in    = ovf_ff;
      age_in    = csr_we ? csr_wdata : age_ff;
      ovalid_in = ovalid_ff && !rsp_chan.ready;
      oent_in   = oent_ff;
      oright_in = oright_ff;
      oleft_in  = oleft_ff;
      oovf_in   = oovf_ff;
      olast_in  = olast_ff;
      step      = 1'b0;
      keep      = 1'b1;
      wrap_data = head;
      for (int i = 0; i < TABLE_DEPTH; i++) tab_in[i] = tab_ff[i];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               priority if (req_chan.mode == MODE_REPORT) begin
                  if (req_chan.track_age >= age_ff) begin
                     id_in    = req_chan.target_id;
                     x_in     = req_chan.pos_x;
                     y_in     = req_chan.pos_y;
                     rem_in   = cnt_ff;
                     kept_in  = '0;
                     found_in = 1'b0;
                     state_in = ST_SCAN;
                  end
               end else if (req_chan.mode == MODE_FRAME) begin
                  rem_in  = cnt_ff;
                  kept_in = '0;
                  if (int'(cnt_ff) < MAX_RESULTS) emit_in = EW'(cnt_ff);
                  else emit_in = EW'(MAX_RESULTS);
                  state_in = ST_FRAME;
               end else if (req_chan.mode == MODE_CLEAR) begin
                  right_in = '0;
                  left_in  = '0;
               end else begin
                  // unused mode, nothing to do
               end
            end
         end
         ST_SCAN: begin
            if (rem_ff != '0) begin
               // every entry stays in the line during a lookup
               step    = 1'b1;
               rem_in  = rem_ff - CW'(1);
               kept_in = kept_ff + CW'(1);
               if (match) begin
                  found_in  = 1'b1;
                  wrap_data = '{id: id_ff, x: x_ff, y: y_ff, seen: 1'b1};
                  if (x_ff < 0 && head.x >= 0) begin
                     if (right_ff != '1) right_in = right_ff + 16'd1;
                  end else if (x_ff >= 0 && head.x < 0) begin
                     if (left_ff != '1) left_in = left_ff + 16'd1;
                  end
               end
            end else begin
               // table back in order, insert a new id at front, or flag overflow when full
               if (!found_ff) begin
                  if (int'(cnt_ff) >= TABLE_DEPTH) begin
                     ovf_in = 1'b1;
                  end else begin
                     for (int i = 1; i < TABLE_DEPTH; i++) tab_in[i] = ins_src[i];
                     tab_in[0] = '{id: id_ff, x: x_ff, y: y_ff, seen: 1'b1};
                     cnt_in    = cnt_ff + CW'(1);
                  end
               end
               state_in = ST_IDLE;
            end
         end
         ST_FRAME: begin
            if (rem_ff != '0) begin
               if (emit_ff == '0 || out_free) begin
                  step   = 1'b1;
                  rem_in = rem_ff - CW'(1);
                  keep   = head.seen;
                  wrap_data.seen = 1'b0;
                  if (head.seen) kept_in = kept_ff + CW'(1);
                  if (emit_ff != '0) begin
                     emit_in   = emit_ff - EW'(1);
                     ovalid_in = 1'b1;
                     oent_in   = head;
                     oright_in = right_ff;
                     oleft_in  = left_ff;
                     oovf_in   = ovf_ff;
                     olast_in  = (emit_ff == EW'(1));
                  end
               end
            end else begin
               cnt_in   = kept_ff;
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // one turn of the line: head goes to the wrap slot or drops out
      if (step) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (keep && IW'(i) == wrap) tab_in[i] = wrap_data;
            else if (IW'(i) <= wrap) tab_in[i] = rot_src[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         rem_ff    <= '0;
         kept_ff   <= '0;
         emit_ff   <= '0;
         found_ff  <= 1'b0;
         right_ff  <= '0;
         left_ff   <= '0;
         ovf_ff    <= 1'b0;
         age_ff    <= AGE_DEF;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         rem_ff    <= rem_in;
         kept_ff   <= kept_in;
         emit_ff   <= emit_in;
         found_ff  <= found_in;
         right_ff  <= right_in;
         left_ff   <= left_in;
         ovf_ff    <= ovf_in;
         age_ff    <= age_in;
         ovalid_ff <= ovalid_in;
      end
   end

   // marks live in the line too, but only slots below the count are ever read
   always_ff @(posedge clock) begin
      for (int i = 0; i < TABLE_DEPTH; i++) tab_ff[i] <= tab_in[i];
      id_ff     <= id_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      oent_ff   <= oent_in;
      oright_ff <= oright_in;
      oleft_ff  <= oleft_in;
      oovf_ff   <= oovf_in;
      olast_ff  <= olast_in;
   end

   assign rsp_chan.valid          = ovalid_ff;
   assign rsp_chan.entry_id       = oent_ff.id;
   assign rsp_chan.seen_now       = oent_ff.seen;
   assign rsp_chan.entry_x        = oent_ff.x;
   assign rsp_chan.entry_y        = oent_ff.y;
   assign rsp_chan.right_total    = oright_ff;
   assign rsp_chan.left_total     = oleft_ff;
   assign rsp_chan.table_overflow = oovf_ff;
   assign rsp_chan.last_in_frame  = olast_ff;

endmodule

// ----- test/tlcc_checker.sv -----
// checker: predicts the id table and compares response words
module tlcc_checker
   import tlcc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   tlcc_req_if.sink   req_mon,
   tlcc_rsp_if.sink   rsp_mon,
   input  logic       csr_we,
   input  logic [15:0] csr_wdata,
   output int         fail_count,
   output int         pending_words
);

   typedef struct packed {
      logic [15:0]        id;
      logic               seen;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [15:0]        right_total;
      logic [15:0]        left_total;
      logic               overflow;
      logic               last;
   } frame_word_t;

   frame_word_t expected_words[$];
   entry_type   track_table[TABLE_DEPTH_DEF];
   int          track_count;
   logic [15:0] age_threshold;
   logic [15:0] right_cnt, left_cnt;
   logic        overflow_flag;

   assign pending_words = expected_words.size();

   // apply one target report to the model table
   task automatic apply_report(logic [15:0] id, logic signed [15:0] x, logic signed [15:0] y);
      int i;
      for (i = 0; i < track_count; i++) begin
         if (track_table[i].id == id) begin
            track_table[i].seen = 1'b1;
            if (x < 0 && track_table[i].x >= 0) begin
               if (right_cnt != 16'hffff) right_cnt++;
            end else if (x >= 0 && track_table[i].x < 0) begin
               if (left_cnt != 16'hffff) left_cnt++;
            end
            track_table[i].x = x;
            track_table[i].y = y;
            return;
         end
      end
      if (track_count >= TABLE_DEPTH_DEF) begin
         overflow_flag = 1'b1;
         return;
      end
      for (i = track_count; i > 0; i--) track_table[i] = track_table[i-1];
      track_table[0] = '{id: id, x: x, y: y, seen: 1'b1};
      track_count++;
   endtask

   // emit the frame words, then drop unseen entries
   task automatic close_frame();
      int n, i, kept;
      frame_word_t w;
      n = track_count < MAX_RESULTS ? track_count : MAX_RESULTS;
      for (i = 0; i < n; i++) begin
         w.id = track_table[i].id;
         w.seen = track_table[i].seen;
         w.x = track_table[i].x;
         w.y = track_table[i].y;
         w.right_total = right_cnt;
         w.left_total = left_cnt;
         w.overflow = overflow_flag;
         w.last = (i + 1 == n);
         expected_words = {expected_words, w};
      end
      kept = 0;
      for (i = 0; i < track_count; i++) begin
         if (track_table[i].seen) begin
            track_table[kept] = track_table[i];
            track_table[kept].seen = 1'b0;
            kept++;
         end
      end
      track_count = kept;
      overflow_flag = 1'b0;
   endtask

   always @(posedge clock) begin
      frame_word_t got, exp_w;
      if (reset) begin
         track_count = 0;
         age_threshold = AGE_DEF;
         right_cnt = '0;
         left_cnt = '0;
         overflow_flag = 1'b0;
         expected_words.delete();
         fail_count = 0;
      end else begin
         if (csr_we) age_threshold = csr_wdata;
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.entry_id, rsp_mon.seen_now, rsp_mon.entry_x, rsp_mon.entry_y,
                    rsp_mon.right_total, rsp_mon.left_total, rsp_mon.table_overflow,
                    rsp_mon.last_in_frame};
            if (expected_words.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected word %p", got);
            end else begin
               exp_w = expected_words.pop_front();
               if (got !== exp_w) begin
                  fail_count++;
                  if (fail_count <= 10) $display("mismatch: expected %p got %p", exp_w, got);
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            case (req_mon.mode)
               MODE_REPORT:
                  if (req_mon.track_age >= age_threshold)
                     apply_report(req_mon.target_id, req_mon.pos_x, req_mon.pos_y);
               MODE_FRAME: close_frame();
               MODE_CLEAR: begin
                  right_cnt = '0;
                  left_cnt = '0;
               end
               default: ;
            endcase
         end
      end
   end

endmodule

// ----- test/testbench.sv -----
// stimulus and verdict for the line crossing counter
module testbench;
   import tlcc_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;
   int          fail_count, pending_words;
   int          quiet_cycles = 0;
   int          stall_left = 0;
   logic        rsp_ready_en = 1'b1;

   localparam int QUIET_LIMIT = 20000;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   tlcc_req_if req_chan();
   tlcc_rsp_if rsp_chan();

   tracked_id_line_crossing_counter_unit i_dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   tlcc_checker i_checker (
      .clock(clock), .reset(reset), .req_mon(req_chan), .rsp_mon(rsp_chan),
      .csr_we(csr_we), .csr_wdata(csr_wdata), .fail_count(fail_count),
      .pending_words(pending_words)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.mode = MODE_REPORT;
      req_chan.target_id = '0;
      req_chan.track_age = '0;
      req_chan.pos_x = '0;
      req_chan.pos_y = '0;
      rsp_chan.ready = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // response side stalls on its own, with the odd long stretch
   always @(posedge clock) begin
      if (!rsp_ready_en) rsp_chan.ready <= 1'b1;
      else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 3) begin
         stall_left <= $urandom_range(10, 40);
         rsp_chan.ready <= 1'b0;
      end else rsp_chan.ready <= ($urandom_range(0, 99) < 70);
   end

   // watchdog: no word moves for too long
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else if (!reset) quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // one request word, held until taken; valid drops only over a gap
   task automatic send_word(logic [1:0] mode, logic [15:0] id, logic [15:0] age,
                            logic [15:0] x, logic [15:0] y);
      int g;
      g = gap_length();
      if (g > 0) begin
         req_chan.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.mode <= mode;
      req_chan.target_id <= id;
      req_chan.track_age <= age;
      req_chan.pos_x <= x;
      req_chan.pos_y <= y;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic report(logic [15:0] id, logic [15:0] age, logic [15:0] x, logic [15:0] y);
      send_word(MODE_REPORT, id, age, x, y);
   endtask

   task automatic frame_end();
      send_word(MODE_FRAME, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   // wait until the request side is idle and every response word is out
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
   endtask

   // write the age threshold once everything has drained
   task automatic set_threshold(logic [15:0] v);
      drain();
      repeat (80) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // a frame of reports drawn from a small id pool so ids recur and cross
   task automatic random_frame(int reports, int id_span);
      int k;
      logic [15:0] x;
      for (k = 0; k < reports; k++) begin
         case ($urandom_range(0, 3))
            0: x = 16'($urandom_range(0, 3)) - 16'd2;
            1: x = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
            default: x = 16'($urandom);
         endcase
         if ($urandom_range(0, 19) == 0)
            send_word(MODE_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom));
         else if ($urandom_range(0, 29) == 0)
            send_word(MODE_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom));
         else
            report(16'($urandom_range(0, id_span)) ^
                      ($urandom_range(0, 9) == 0 ? 16'hff00 : 16'h0000),
                   $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(40, 200)),
                   x, 16'($urandom));
      end
      frame_end();
   endtask

   initial begin
      int f, k;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty frame, extremes, crossings both ways, young target
      frame_end();
      report(16'h0000, 16'd50, 16'h0000, 16'h7fff);
      report(16'hffff, 16'hffff, 16'h8000, 16'h8000);
      report(16'h1234, 16'd49, 16'h0001, 16'h0001);
      report(16'h0000, 16'd60, 16'hffff, 16'h0000);
      report(16'h0000, 16'd60, 16'h0000, 16'h0001);
      report(16'hffff, 16'd99, 16'h7fff, 16'hffff);
      send_word(MODE_UNUSED, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
      frame_end();
      frame_end();
      send_word(MODE_CLEAR, '0, '0, '0, '0);
      frame_end();
      frame_end();

      // minimum threshold: fill past the table depth to force overflow
      set_threshold(16'h0000);
      for (k = 0; k < 36; k++) report(k[15:0], 16'h0000, k[0] ? 16'h8000 : 16'h0005, k[15:0]);
      frame_end();

      // one id swinging sign repeatedly, response side always ready
      set_threshold(16'd10);
      rsp_ready_en = 1'b0;
      for (k = 0; k < 70; k++) report(16'h00aa, 16'd10, k[0] ? 16'h0003 : 16'hfffd, 16'h0);
      frame_end();
      rsp_ready_en = 1'b1;

      // maximum threshold: only full age reports count
      set_threshold(16'hffff);
      random_frame(12, 15);

      // random part over several thresholds
      for (f = 0; f < 40; f++) begin
         if (f % 10 == 0) set_threshold(f == 20 ? 16'd0 : 16'($urandom_range(30, 120)));
         random_frame($urandom_range(0, 15), $urandom_range(0, 3) == 0 ? 60 : 12);
      end

      drain();
      repeat (100) @(posedge clock);
      if (fail_count == 0) $display("testbench: clean");
      else $display("testbench: errors");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/tlcc_pkg.sv
rtl/core/tlcc_ifs.sv
rtl/core/tracked_id_line_crossing_counter_unit.sv
test/tlcc_checker.sv
test/testbench.sv
